FILE: design/stpg_pkg.sv
// ----------------------------------------------------------------------------
// stpg_pkg
// Shared types and constants of the stepper ramp pulse generator.
// ----------------------------------------------------------------------------
`default_nettype none

package stpg_pkg;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 20;
    localparam int AMOUNT_BITS    = 16;
    localparam int SPU_BITS       = 20;
    localparam int PRODUCT_BITS   = AMOUNT_BITS + SPU_BITS;
    localparam int RAMP_BITS      = 17;

    localparam logic [RAMP_BITS-1:0] RAMP_MAX = '1;

    localparam logic [1:0] ACT_TICK = 2'd0;
    localparam logic [1:0] ACT_RAMP = 2'd1;
    localparam logic [1:0] ACT_FINE = 2'd2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_START_HP  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CRUISE_HP = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RAMP_STEP = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPU       = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FINE_HP   = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MOTOR_EN  = 3'd5;

    localparam logic [15:0]         RST_START_HP  = 16'd100;
    localparam logic [15:0]         RST_CRUISE_HP = 16'd1;
    localparam logic [15:0]         RST_RAMP_STEP = 16'd1;
    localparam logic [SPU_BITS-1:0] RST_SPU       = 20'(12800 * 5 / 3);
    localparam logic [15:0]         RST_FINE_HP   = 16'd3;
    localparam logic                RST_MOTOR_EN  = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_ACCEL  = 3'd1,
        PH_CRUISE = 3'd2,
        PH_DECEL  = 3'd3,
        PH_FINE   = 3'd4
    } phase_t;

    typedef struct packed {
        logic [15:0]         start_hp;
        logic [15:0]         cruise_hp;
        logic [15:0]         ramp_step;
        logic [SPU_BITS-1:0] steps_per_unit;
        logic [15:0]         fine_hp;
        logic                motor_enable;
    } cfg_t;

    typedef struct packed {
        logic [1:0]             action;
        logic                   motor_select;
        logic                   direction;
        logic [AMOUNT_BITS-1:0] amount;
    } in_beat_t;

    typedef struct packed {
        logic left_step;
        logic right_step;
        logic left_direction;
        logic right_direction;
        logic enable_level;
        logic busy_res;
        logic move_done;
        logic rejected;
    } out_beat_t;

    typedef struct packed {
        in_beat_t                beat;
        logic [PRODUCT_BITS-1:0] product;
    } stage_t;

endpackage

`default_nettype wire

FILE: design/stpg_cfg_regs.sv
// ----------------------------------------------------------------------------
// stpg_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module stpg_cfg_regs
    import stpg_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_wr_en,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_addr,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_wr_data,
    output cfg_t                           cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_START_HP:  cfg_next.start_hp       = cfg_wr_data[15:0];
                CFG_CRUISE_HP: cfg_next.cruise_hp      = cfg_wr_data[15:0];
                CFG_RAMP_STEP: cfg_next.ramp_step      = cfg_wr_data[15:0];
                CFG_SPU:       cfg_next.steps_per_unit = cfg_wr_data[SPU_BITS-1:0];
                CFG_FINE_HP:   cfg_next.fine_hp        = cfg_wr_data[15:0];
                CFG_MOTOR_EN:  cfg_next.motor_enable   = cfg_wr_data[0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_hp       <= RST_START_HP;
            cfg_reg.cruise_hp      <= RST_CRUISE_HP;
            cfg_reg.ramp_step      <= RST_RAMP_STEP;
            cfg_reg.steps_per_unit <= RST_SPU;
            cfg_reg.fine_hp        <= RST_FINE_HP;
            cfg_reg.motor_enable   <= RST_MOTOR_EN;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: design/stpg_in_stage.sv
// ----------------------------------------------------------------------------
// stpg_in_stage
// Input register; forms the move length product of each accepted beat.
// ----------------------------------------------------------------------------
`default_nettype none

module stpg_in_stage
    import stpg_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_beat_t s_data,
    input  wire logic [SPU_BITS-1:0] steps_per_unit,
    input  wire logic     advance,
    output logic          stage_valid,
    output stage_t        stage
);

    logic   valid_reg;
    logic   valid_next;
    stage_t stage_reg;
    logic   accept;

    assign s_ready = !valid_reg || advance;
    assign accept  = s_valid && s_ready;

    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            stage_reg.beat    <= s_data;
            stage_reg.product <= PRODUCT_BITS'(s_data.amount) * PRODUCT_BITS'(steps_per_unit);
        end
    end

    assign stage_valid = valid_reg;
    assign stage       = stage_reg;

endmodule

`default_nettype wire

FILE: design/stpg_engine.sv
// ----------------------------------------------------------------------------
// stpg_engine
// Move state machine, pulse timing and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module stpg_engine
    import stpg_pkg::*;
#(
    parameter int HPB = 16,
    parameter int TCB = 40
) (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire cfg_t   cfg,
    input  wire logic   stage_valid,
    input  wire stage_t stage,
    output logic        advance,
    output logic        m_valid,
    input  wire logic   m_ready,
    output out_beat_t   m_data
);

    function automatic logic [HPB-1:0] eff_hp(input logic [15:0] v);
        logic [HPB+15:0] w;
        logic [HPB-1:0]  x;
        w = {{HPB{1'b0}}, v};
        x = w[HPB-1:0];
        return (x == '0) ? HPB'(1) : x;
    endfunction

    phase_t               phase_reg, phase_next;
    logic [HPB-1:0]       hp_reg, hp_next;
    logic [HPB-1:0]       cd_reg, cd_next;
    logic                 lvl_reg, lvl_next;
    logic [TCB-1:0]       pc_reg, pc_next;
    logic [RAMP_BITS-1:0] rpc_reg, rpc_next;
    logic [TCB-1:0]       total_reg, total_next;
    logic                 motor_reg, motor_next;
    logic                 ldir_reg, ldir_next;
    logic                 rdir_reg, rdir_next;
    logic                 m_valid_reg, m_valid_next;
    out_beat_t            out_reg, out_next;

    logic                      fire;
    logic [HPB-1:0]            c_hp, s_hp, st_hp, f_hp;
    logic                      c_lt_s;
    logic [HPB-1:0]            cd_dec;
    logic [RAMP_BITS-1:0]      rpc_inc;
    logic [TCB-1:0]            twice;
    logic [TCB-1:0]            cruise_left;
    logic [TCB-1:0]            pc_dec;
    logic [PRODUCT_BITS+TCB-1:0] prod_wide;
    logic [TCB-1:0]            prod_total;
    logic                      is_start;
    logic                      lch, fin, rej, lvl_out;
    phase_t                    lch_phase;
    logic [HPB-1:0]            lch_hp;

    assign advance = !m_valid_reg || m_ready;
    assign fire    = stage_valid && advance;

    assign c_hp   = eff_hp(cfg.cruise_hp);
    assign s_hp   = eff_hp(cfg.start_hp);
    assign st_hp  = eff_hp(cfg.ramp_step);
    assign f_hp   = eff_hp(cfg.fine_hp);
    assign c_lt_s = c_hp < s_hp;

    assign cd_dec      = (cd_reg != '0) ? cd_reg - HPB'(1) : cd_reg;
    assign rpc_inc     = (rpc_reg != RAMP_MAX) ? rpc_reg + RAMP_BITS'(1) : rpc_reg;
    assign twice       = TCB'({rpc_inc, 1'b0});
    assign cruise_left = (total_reg > twice) ? total_reg - twice : '0;
    assign pc_dec      = pc_reg - TCB'(1);
    assign prod_wide   = {{TCB{1'b0}}, stage.product};
    assign prod_total  = prod_wide[TCB-1:0];
    assign is_start    = (stage.beat.action == ACT_RAMP) || (stage.beat.action == ACT_FINE);

    always_comb begin
        phase_next = phase_reg;
        hp_next    = hp_reg;
        cd_next    = cd_reg;
        lvl_next   = lvl_reg;
        pc_next    = pc_reg;
        rpc_next   = rpc_reg;
        total_next = total_reg;
        motor_next = motor_reg;
        ldir_next  = ldir_reg;
        rdir_next  = rdir_reg;
        lch        = 1'b0;
        fin        = 1'b0;
        rej        = 1'b0;
        lch_phase  = PH_IDLE;
        lch_hp     = c_hp;

        if (is_start && phase_reg == PH_IDLE) begin
            motor_next = stage.beat.motor_select;
            if (stage.beat.motor_select) begin
                rdir_next = stage.beat.direction;
            end else begin
                ldir_next = stage.beat.direction;
            end
            rpc_next = '0;
            if (stage.beat.action == ACT_RAMP) begin
                total_next = prod_total;
                if (s_hp > c_hp) begin
                    lch       = 1'b1;
                    lch_phase = PH_ACCEL;
                    lch_hp    = s_hp;
                end else begin
                    pc_next = prod_total;
                    if (prod_total != '0) begin
                        lch       = 1'b1;
                        lch_phase = PH_CRUISE;
                        lch_hp    = c_hp;
                    end else if (c_lt_s) begin
                        lch       = 1'b1;
                        lch_phase = PH_DECEL;
                        lch_hp    = c_hp;
                    end else begin
                        fin = 1'b1;
                    end
                end
            end else begin
                total_next = TCB'(stage.beat.amount);
                pc_next    = TCB'(stage.beat.amount);
                if (stage.beat.amount != '0) begin
                    lch       = 1'b1;
                    lch_phase = PH_FINE;
                    lch_hp    = f_hp;
                end else begin
                    fin = 1'b1;
                end
            end
        end else begin
            rej = is_start;
            if (phase_reg != PH_IDLE) begin
                cd_next = cd_dec;
                if (cd_dec == '0) begin
                    if (lvl_reg) begin
                        lvl_next = 1'b0;
                        cd_next  = hp_reg;
                    end else begin
                        unique case (phase_reg)
                            PH_ACCEL: begin
                                rpc_next = rpc_inc;
                                if (hp_reg > c_hp && (hp_reg - c_hp) > st_hp) begin
                                    lch       = 1'b1;
                                    lch_phase = PH_ACCEL;
                                    lch_hp    = hp_reg - st_hp;
                                end else begin
                                    pc_next = cruise_left;
                                    if (cruise_left != '0) begin
                                        lch       = 1'b1;
                                        lch_phase = PH_CRUISE;
                                        lch_hp    = c_hp;
                                    end else if (c_lt_s) begin
                                        lch       = 1'b1;
                                        lch_phase = PH_DECEL;
                                        lch_hp    = c_hp;
                                    end else begin
                                        fin = 1'b1;
                                    end
                                end
                            end
                            PH_CRUISE: begin
                                pc_next = pc_dec;
                                if (pc_dec != '0) begin
                                    lch       = 1'b1;
                                    lch_phase = PH_CRUISE;
                                    lch_hp    = hp_reg;
                                end else if (c_lt_s) begin
                                    lch       = 1'b1;
                                    lch_phase = PH_DECEL;
                                    lch_hp    = c_hp;
                                end else begin
                                    fin = 1'b1;
                                end
                            end
                            PH_DECEL: begin
                                if (hp_reg < s_hp && (s_hp - hp_reg) > st_hp) begin
                                    lch       = 1'b1;
                                    lch_phase = PH_DECEL;
                                    lch_hp    = hp_reg + st_hp;
                                end else begin
                                    fin = 1'b1;
                                end
                            end
                            PH_FINE: begin
                                pc_next = pc_dec;
                                if (pc_dec != '0) begin
                                    lch       = 1'b1;
                                    lch_phase = PH_FINE;
                                    lch_hp    = hp_reg;
                                end else begin
                                    fin = 1'b1;
                                end
                            end
                            default: begin
                                fin = 1'b1;
                            end
                        endcase
                    end
                end
            end
        end

        if (lch) begin
            phase_next = lch_phase;
            hp_next    = lch_hp;
            cd_next    = lch_hp;
            lvl_next   = 1'b1;
        end
        if (fin) begin
            phase_next = PH_IDLE;
            cd_next    = '0;
            lvl_next   = 1'b0;
        end

        lvl_out                  = (phase_next != PH_IDLE) && lvl_next;
        out_next.left_step       = !motor_next && lvl_out;
        out_next.right_step      = motor_next && lvl_out;
        out_next.left_direction  = ldir_next;
        out_next.right_direction = rdir_next;
        out_next.enable_level    = cfg.motor_enable;
        out_next.busy_res        = phase_next != PH_IDLE;
        out_next.move_done       = fin;
        out_next.rejected        = rej;
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            hp_reg      <= '0;
            cd_reg      <= '0;
            lvl_reg     <= 1'b0;
            pc_reg      <= '0;
            rpc_reg     <= '0;
            total_reg   <= '0;
            motor_reg   <= 1'b0;
            ldir_reg    <= 1'b0;
            rdir_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (fire) begin
                phase_reg <= phase_next;
                hp_reg    <= hp_next;
                cd_reg    <= cd_next;
                lvl_reg   <= lvl_next;
                pc_reg    <= pc_next;
                rpc_reg   <= rpc_next;
                total_reg <= total_next;
                motor_reg <= motor_next;
                ldir_reg  <= ldir_next;
                rdir_reg  <= rdir_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

FILE: design/stepper_ramp_pulse_generator_core.sv
// ----------------------------------------------------------------------------
// stepper_ramp_pulse_generator_core
// Trapezoidal ramp step pulse generator for a left and a right stepper motor.
// ----------------------------------------------------------------------------
// Every input beat is one tick or a start command, and every beat yields one
// result beat. A new beat is accepted in every cycle while the result side
// keeps taking beats; each beat passes first through the input register
// (where the amount times steps-per-unit product is formed) and then through
// the move state update that loads the result register. The rate is set by
// the state update of the move sequencer.
// Configuration takes effect at once and needs no clearing after reset.
`default_nettype none

module stepper_ramp_pulse_generator_core
    import stpg_pkg::*;
#(
    parameter int HALF_PERIOD_BITS = 16,
    parameter int TOTAL_COUNT_BITS = 40
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire in_beat_t                  s_data,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output out_beat_t                      m_data,
    input  wire logic                      cfg_wr_en,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_addr,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_wr_data
);

    cfg_t   cfg;
    stage_t stage;
    logic   stage_valid;
    logic   advance;

    stpg_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    stpg_in_stage u_in (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .steps_per_unit (cfg.steps_per_unit),
        .advance        (advance),
        .stage_valid    (stage_valid),
        .stage          (stage)
    );

    stpg_engine #(
        .HPB (HALF_PERIOD_BITS),
        .TCB (TOTAL_COUNT_BITS)
    ) u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .stage_valid (stage_valid),
        .stage       (stage),
        .advance     (advance),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

`default_nettype wire

FILE: design/stpg_checker.sv
// ----------------------------------------------------------------------------
// stpg_checker
// Port-level checks of the result channel of the pulse generator.
// ----------------------------------------------------------------------------
`default_nettype none

module stpg_checker
    import stpg_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_beat_t m_data
);

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result beat changed");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_one_motor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.left_step && m_data.right_step))
        else $error("both motors stepping");

    a_step_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.left_step || m_data.right_step) |-> m_data.busy_res)
        else $error("step level high while idle");

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.move_done |-> !m_data.busy_res)
        else $error("move done while still busy");

endmodule

bind stepper_ramp_pulse_generator_core stpg_checker u_stpg_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

FILE: tb/stpg_level_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stpg_level_checker
// Watches the beat channels and the register port of the stepper ramp pulse
// generator, predicts every result beat from its own model of the move
// sequencer and compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module stpg_level_checker
    import stpg_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  in_beat_t                  s_data,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  out_beat_t                 m_data,
    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_addr,
    input  logic [CFG_DATA_BITS-1:0]  cfg_wr_data,
    output int                        fail_count,
    output int                        pending,
    output logic                      move_busy
);

    localparam int TOTAL_BITS = 40;

    cfg_t                  regs;
    phase_t                ph;
    logic [15:0]           hp_now;
    logic [15:0]           countdown;
    logic                  step_lvl;
    logic [TOTAL_BITS-1:0] pulses_left;
    logic [TOTAL_BITS-1:0] total;
    logic [RAMP_BITS-1:0]  ramp_pulses;
    logic                  motor_sel;
    logic                  left_dir;
    logic                  right_dir;
    logic                  done;

    out_beat_t predicted_levels[$];

    initial begin
        fail_count = 0;
        pending    = 0;
        move_busy  = 1'b0;
    end

    function automatic logic [15:0] at_least_one(input logic [15:0] v);
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

    function automatic void fire_pulse(input logic [15:0] hp);
        hp_now    = at_least_one(hp);
        countdown = hp_now;
        step_lvl  = 1'b1;
    endfunction

    function automatic void stop_move();
        ph        = PH_IDLE;
        step_lvl  = 1'b0;
        countdown = 16'd0;
        done      = 1'b1;
    endfunction

    function automatic void start_decel();
        logic [15:0] c;
        logic [15:0] s;
        c = at_least_one(regs.cruise_hp);
        s = at_least_one(regs.start_hp);
        if (c < s) begin
            ph = PH_DECEL;
            fire_pulse(c);
        end else begin
            stop_move();
        end
    endfunction

    function automatic void start_cruise();
        logic [TOTAL_BITS-1:0] twice;
        twice       = ramp_pulses;
        twice       = twice << 1;
        pulses_left = (total > twice) ? total - twice : '0;
        if (pulses_left != '0) begin
            ph = PH_CRUISE;
            fire_pulse(at_least_one(regs.cruise_hp));
        end else begin
            start_decel();
        end
    endfunction

    function automatic void end_of_pulse();
        logic [15:0] c;
        logic [15:0] s;
        logic [15:0] st;
        c  = at_least_one(regs.cruise_hp);
        s  = at_least_one(regs.start_hp);
        st = at_least_one(regs.ramp_step);
        case (ph)
            PH_ACCEL: begin
                if (ramp_pulses != RAMP_MAX) ramp_pulses = ramp_pulses + 1'b1;
                if (hp_now > c && (hp_now - c) > st) fire_pulse(hp_now - st);
                else start_cruise();
            end
            PH_CRUISE, PH_FINE: begin
                pulses_left = pulses_left - 1'b1;
                if (pulses_left != '0) fire_pulse(hp_now);
                else if (ph == PH_CRUISE) start_decel();
                else stop_move();
            end
            PH_DECEL: begin
                if (hp_now < s && (s - hp_now) > st) fire_pulse(hp_now + st);
                else stop_move();
            end
            default: stop_move();
        endcase
    endfunction

    function automatic void pass_tick();
        if (ph == PH_IDLE) return;
        if (countdown != 16'd0) countdown = countdown - 1'b1;
        if (countdown == 16'd0) begin
            if (step_lvl) begin
                step_lvl  = 1'b0;
                countdown = hp_now;
            end else begin
                end_of_pulse();
            end
        end
    endfunction

    function automatic out_beat_t predict_levels(input in_beat_t b);
        out_beat_t             r;
        logic                  rej;
        logic                  lvl;
        logic [TOTAL_BITS-1:0] amt_wide;
        logic [TOTAL_BITS-1:0] spu_wide;
        done = 1'b0;
        rej  = 1'b0;
        if (b.action == ACT_RAMP || b.action == ACT_FINE) begin
            if (ph != PH_IDLE) begin
                rej = 1'b1;
                pass_tick();
            end else begin
                motor_sel = b.motor_select;
                if (b.motor_select) right_dir = b.direction;
                else left_dir = b.direction;
                ramp_pulses = '0;
                amt_wide    = b.amount;
                if (b.action == ACT_RAMP) begin
                    spu_wide = regs.steps_per_unit;
                    total    = amt_wide * spu_wide;
                    if (at_least_one(regs.start_hp) > at_least_one(regs.cruise_hp)) begin
                        ph = PH_ACCEL;
                        fire_pulse(at_least_one(regs.start_hp));
                    end else begin
                        start_cruise();
                    end
                end else begin
                    total       = amt_wide;
                    pulses_left = amt_wide;
                    if (b.amount != '0) begin
                        ph = PH_FINE;
                        fire_pulse(at_least_one(regs.fine_hp));
                    end else begin
                        stop_move();
                    end
                end
            end
        end else begin
            pass_tick();
        end
        lvl               = (ph != PH_IDLE) && step_lvl;
        r.left_step       = !motor_sel && lvl;
        r.right_step      = motor_sel && lvl;
        r.left_direction  = left_dir;
        r.right_direction = right_dir;
        r.enable_level    = regs.motor_enable;
        r.busy_res        = (ph != PH_IDLE);
        r.move_done       = done;
        r.rejected        = rej;
        return r;
    endfunction

    function automatic string describe(input out_beat_t v);
        return $sformatf("step L%0b R%0b dir L%0b R%0b en %0b busy %0b done %0b rej %0b",
                         v.left_step, v.right_step, v.left_direction, v.right_direction,
                         v.enable_level, v.busy_res, v.move_done, v.rejected);
    endfunction

    always @(posedge aclk) begin
        out_beat_t want;
        if (!aresetn) begin
            regs.start_hp       = RST_START_HP;
            regs.cruise_hp      = RST_CRUISE_HP;
            regs.ramp_step      = RST_RAMP_STEP;
            regs.steps_per_unit = RST_SPU;
            regs.fine_hp        = RST_FINE_HP;
            regs.motor_enable   = RST_MOTOR_EN;
            ph          = PH_IDLE;
            hp_now      = '0;
            countdown   = '0;
            step_lvl    = 1'b0;
            pulses_left = '0;
            total       = '0;
            ramp_pulses = '0;
            motor_sel   = 1'b0;
            left_dir    = 1'b0;
            right_dir   = 1'b0;
            done        = 1'b0;
            predicted_levels.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_START_HP:  regs.start_hp       = cfg_wr_data[15:0];
                    CFG_CRUISE_HP: regs.cruise_hp      = cfg_wr_data[15:0];
                    CFG_RAMP_STEP: regs.ramp_step      = cfg_wr_data[15:0];
                    CFG_SPU:       regs.steps_per_unit = cfg_wr_data[SPU_BITS-1:0];
                    CFG_FINE_HP:   regs.fine_hp        = cfg_wr_data[15:0];
                    CFG_MOTOR_EN:  regs.motor_enable   = cfg_wr_data[0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) predicted_levels.push_back(predict_levels(s_data));
            if (m_valid && m_ready) begin
                if (predicted_levels.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: result beat with nothing predicted: %s",
                                 $time, describe(m_data));
                end else begin
                    want = predicted_levels.pop_front();
                    if (want !== m_data) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: mismatch\n  expected %s\n  actual   %s",
                                     $time, describe(want), describe(m_data));
                    end
                end
            end
        end
        pending   = predicted_levels.size();
        move_busy = (ph != PH_IDLE);
    end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the stepper ramp pulse generator: directed moves
// at reset, special and extreme register settings, then random register
// settings with random move and tick beats under sender gaps and receiver
// stalls. Checking is done by the level checker beside the block.
// ----------------------------------------------------------------------------
module tb_top;
    import stpg_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;

    logic                      aclk    = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    in_beat_t                  s_data  = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    out_beat_t                 m_data;
    logic                      cfg_wr_en   = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_addr    = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_wr_data = '0;

    int   fail_count;
    int   pending;
    logic move_busy;

    int burst_left = 0;
    int stall_left = 0;
    int stall_pct  = 0;
    int epoch      = 0;

    always #5 aclk = ~aclk;

    stepper_ramp_pulse_generator_core u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    stpg_level_checker u_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .fail_count  (fail_count),
        .pending     (pending),
        .move_busy   (move_busy)
    );

    // Receiver: epochs of no stalls, rare stalls and frequent stalls.
    always @(negedge aclk) begin
        if (epoch == 0) begin
            epoch = $urandom_range(200, 2000);
            case ($urandom_range(0, 2))
                0:       stall_pct = 0;
                1:       stall_pct = 5;
                default: stall_pct = 25;
            endcase
        end
        epoch--;
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(0, 5);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Called and returns at a falling edge.
    task automatic send_beat(input logic [1:0] act, input logic sel, input logic dir,
                             input logic [15:0] amt);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= {act, sel, dir, amt};
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic send_tick();
        send_beat(ACT_TICK, 1'($urandom), 1'($urandom), 16'($urandom));
    endtask

    task automatic run_out_move();
        while (move_busy) send_tick();
    endtask

    // Drain every predicted result, then write all registers.
    task automatic write_config(input logic [15:0] start_hp, input logic [15:0] cruise_hp,
                                input logic [15:0] ramp_step, input logic [19:0] spu,
                                input logic [15:0] fine_hp, input logic enable);
        s_valid <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= CFG_START_HP;
        cfg_wr_data <= start_hp;
        @(negedge aclk);
        cfg_addr    <= CFG_CRUISE_HP;
        cfg_wr_data <= cruise_hp;
        @(negedge aclk);
        cfg_addr    <= CFG_RAMP_STEP;
        cfg_wr_data <= ramp_step;
        @(negedge aclk);
        cfg_addr    <= CFG_SPU;
        cfg_wr_data <= spu;
        @(negedge aclk);
        cfg_addr    <= CFG_FINE_HP;
        cfg_wr_data <= fine_hp;
        @(negedge aclk);
        cfg_addr    <= CFG_MOTOR_EN;
        cfg_wr_data <= enable;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        int         roll;
        logic [1:0] act;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset settings: idle beats, a fine move with a rejected start, a
        // ramp from the reset start half period, cut short by a large step.
        send_beat(ACT_TICK, 1'b1, 1'b1, 16'hFFFF);
        send_beat(ACT_UNUSED, 1'b0, 1'b0, 16'h0000);
        send_beat(ACT_FINE, 1'b1, 1'b1, 16'd2);
        send_tick();
        send_beat(ACT_RAMP, 1'b0, 1'b0, 16'hFFFF);
        send_beat(ACT_UNUSED, 1'b1, 1'b0, 16'h5A5A);
        run_out_move();
        send_beat(ACT_RAMP, 1'b0, 1'b1, 16'd0);
        repeat (5) send_tick();
        write_config(16'd3, 16'd2, 16'hFFFF, 20'd3, 16'd1, 1'b0);
        run_out_move();

        // Short ramps, with and without cruise; empty fine move.
        write_config(16'd6, 16'd2, 16'd1, 20'd3, 16'd1, 1'b0);
        send_beat(ACT_RAMP, 1'b0, 1'b0, 16'd1);
        run_out_move();
        send_beat(ACT_RAMP, 1'b1, 1'b1, 16'd5);
        send_tick();
        send_beat(ACT_FINE, 1'b0, 1'b1, 16'd7);
        run_out_move();
        send_beat(ACT_FINE, 1'b0, 1'b1, 16'd0);
        send_beat(ACT_FINE, 1'b1, 1'b0, 16'd3);
        run_out_move();

        // Start at or below cruise: straight into cruise, empty ramp move.
        write_config(16'd2, 16'd5, 16'd3, 20'd2, 16'd2, 1'b1);
        send_beat(ACT_RAMP, 1'b1, 1'b1, 16'd2);
        run_out_move();
        send_beat(ACT_RAMP, 1'b0, 1'b1, 16'd0);

        // Zero half periods and ramp step read as one.
        write_config(16'd0, 16'd0, 16'd0, 20'd1, 16'd0, 1'b1);
        send_beat(ACT_RAMP, 1'b0, 1'b0, 16'd3);
        run_out_move();
        send_beat(ACT_FINE, 1'b1, 1'b1, 16'd2);
        run_out_move();

        // Register extremes.
        write_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 20'hFFFFF, 16'hFFFF, 1'b1);
        send_beat(ACT_RAMP, 1'b1, 1'b0, 16'd0);
        send_beat(ACT_FINE, 1'b0, 1'b0, 16'd0);
        write_config(16'd5, 16'd1, 16'hFFFF, 20'hFFFFF, 16'd1, 1'b0);
        send_beat(ACT_RAMP, 1'b1, 1'b1, 16'd0);
        send_beat(ACT_FINE, 1'b0, 1'b1, 16'hFFFF);
        run_out_move();

        // Random settings and beats.
        repeat (8) begin
            write_config(($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 9)),
                         ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 5)),
                         ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 3)),
                         20'($urandom_range(1, 4)),
                         16'($urandom_range(0, 4)),
                         1'($urandom));
            repeat (150) begin
                act = $urandom_range(0, 1) ? ACT_RAMP : ACT_FINE;
                if (!move_busy && $urandom_range(0, 99) < 35) begin
                    send_beat(act, 1'($urandom), 1'($urandom),
                              (act == ACT_RAMP) ? 16'($urandom_range(0, 5))
                                                : 16'($urandom_range(0, 12)));
                end else begin
                    roll = $urandom_range(0, 99);
                    if (roll < 5)
                        send_beat(act, 1'($urandom), 1'($urandom),
                                  move_busy ? 16'($urandom) : 16'($urandom_range(0, 5)));
                    else if (roll < 9)
                        send_beat(ACT_UNUSED, 1'($urandom), 1'($urandom), 16'($urandom));
                    else
                        send_tick();
                end
            end
        end

        // Widest product; the move outlasts the run.
        write_config(16'd4, 16'd1, 16'd1, 20'hFFFFF, 16'd2, 1'b1);
        send_beat(ACT_RAMP, 1'b0, 1'b1, 16'hFFFF);
        repeat (100) send_tick();

        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
